>>> src/enfp_pkg.sv
// Shared types and constants of the EMG noise floor and peak hold detector.
`default_nettype none

package enfp_pkg;

	// Build defaults for the top level parameters.
	localparam int CHANNELS_DEF     = 2;
	localparam int NOISE_DEPTH_DEF  = 16;
	localparam int NOISE_PRESET_DEF = 300;

	// Field widths.
	localparam int SAMPLE_W   = 10;
	localparam int TICKS_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS     = 2'd1;

	// Register reset values.
	localparam logic [SAMPLE_W-1:0] THR_RESET  = 10'd200;
	localparam logic [TICKS_W-1:0]  HOLD_RESET = 16'd1000;

	// The noise gate opens at the mean plus a third of the threshold.
	localparam int DAMPING = 3;
	localparam logic [SAMPLE_W-1:0] THR3_RESET = SAMPLE_W'(200 / DAMPING);
	// floor(x / 3) for any 10-bit x equals (x * 683) >> 11.
	localparam int DAMP_RECIP = 683;
	localparam int DAMP_SHIFT = 11;

	localparam logic [TICKS_W-1:0] TICK_MAX = 16'hFFFF;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	// An item leaving the noise floor tracker, with its updated mean.
	typedef struct packed {
		logic                valid;
		logic                tick;
		logic                ch;
		logic [SAMPLE_W-1:0] smp;
		logic [SAMPLE_W-1:0] mean;
	} floor_res_t;

	// One result item.
	typedef struct packed {
		logic                ch;
		logic [SAMPLE_W-1:0] amp;
		logic                active;
		logic                peak;
		logic                hold;
		logic [SAMPLE_W-1:0] mean;
	} result_t;

endpackage

`default_nettype wire

>>> src/emg_noise_floor_peak_hold_detector.sv
// Top level of the EMG noise floor and peak hold detector.
// A sample result passes the tracker stages s1 to s3, then the output register.
// Throughput: one request per cycle unless stalled; the noise store is read at
// acceptance, written back from s1; a slot forward covers back-to-back samples.
// Ticks and samples for an unbuilt channel give no result.
// Reset sets control state and config to reset values; the store needs no pass.
`default_nettype none

module emg_noise_floor_peak_hold_detector #(
	parameter int CHANNELS     = enfp_pkg::CHANNELS_DEF,
	parameter int NOISE_DEPTH  = enfp_pkg::NOISE_DEPTH_DEF,
	parameter int NOISE_PRESET = enfp_pkg::NOISE_PRESET_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,

	input  wire logic                            item_valid,
	output logic                                 item_stall,
	input  wire logic                            operation,
	input  wire logic                            channel,
	input  wire logic [enfp_pkg::SAMPLE_W-1:0]   sample,

	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output logic                                 out_channel,
	output logic      [enfp_pkg::SAMPLE_W-1:0]   amplitude,
	output logic                                 active,
	output logic                                 peak,
	output logic                                 hold,
	output logic      [enfp_pkg::SAMPLE_W-1:0]   noise_mean,

	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [enfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [enfp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import enfp_pkg::*;

	localparam int D3W = SAMPLE_W + DAMP_SHIFT;

	// Configuration registers. The third of the threshold is formed once, at
	// write time, so the noise gate sees it as a plain register.
	logic [SAMPLE_W-1:0] thr_q;
	logic [SAMPLE_W-1:0] thr3_q;
	logic [TICKS_W-1:0]  hold_q;
	logic [D3W-1:0]      thr_mul;

	// Output register with its own valid; it parts the pipeline from the
	// downstream stall; requests enter while a result waits if no sample needs it.
	logic    result_valid_q;
	result_t result_q;

	floor_res_t fl_res;
	result_t    pk_res;
	logic       pk_valid;
	logic       adv;
	logic       accept;
	logic       ent_valid;
	logic       ent_tick;
	logic       ent_ch;

	assign cfg_ready = 1'b1;
	assign thr_mul   = D3W'(cfg_data[SAMPLE_W-1:0]) * D3W'(DAMP_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			thr3_q <= THR3_RESET;
			hold_q <= HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PEAK_THRESHOLD: begin
					thr_q  <= cfg_data[SAMPLE_W-1:0];
					thr3_q <= thr_mul[DAMP_SHIFT +: SAMPLE_W];
				end
				REG_HOLD_TICKS: begin
					hold_q <= cfg_data[TICKS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The whole pipeline moves together. It stops only when the result
	// register is full, downstream is stalling, and the last stage holds a
	// sample that would need the register.
	assign adv        = !(result_valid_q && result_stall && pk_valid);
	assign item_stall = !adv;
	assign accept     = item_valid && !item_stall;

	// A sample for a channel that is not built is dropped at the door.
	assign ent_tick  = (operation == OP_TICK);
	assign ent_valid = accept && (ent_tick || (CHANNELS > 1) || (channel == 1'b0));
	assign ent_ch    = (CHANNELS > 1) ? channel : 1'b0;

	enfp_floor #(
		.CHANNELS     (CHANNELS),
		.NOISE_DEPTH  (NOISE_DEPTH),
		.NOISE_PRESET (NOISE_PRESET)
	) u_floor (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ent_valid (ent_valid),
		.ent_tick  (ent_tick),
		.ent_ch    (ent_ch),
		.ent_smp   (sample),
		.thr3      (thr3_q),
		.res       (fl_res)
	);

	enfp_peak #(
		.CHANNELS (CHANNELS)
	) u_peak (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.item       (fl_res),
		.thr        (thr_q),
		.hold_ticks (hold_q),
		.res        (pk_res),
		.res_valid  (pk_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv && pk_valid) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pk_valid) begin
			result_q <= pk_res;
		end
	end

	assign result_valid = result_valid_q;
	assign out_channel  = result_q.ch;
	assign amplitude    = result_q.amp;
	assign active       = result_q.active;
	assign peak         = result_q.peak;
	assign hold         = result_q.hold;
	assign noise_mean   = result_q.mean;

endmodule

`default_nettype wire

>>> src/enfp_noise_ram.sv
// Noise sample ring store: one read and one write port, registered read data.
`default_nettype none

module enfp_noise_ram #(
	parameter int DEPTH  = enfp_pkg::CHANNELS_DEF * enfp_pkg::NOISE_DEPTH_DEF,
	parameter int AW     = $clog2(DEPTH),
	parameter int PRESET = enfp_pkg::NOISE_PRESET_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rd_en,
	input  wire logic [AW-1:0]                 rd_addr,
	output logic      [enfp_pkg::SAMPLE_W-1:0] rd_data,
	input  wire logic                          wr_en,
	input  wire logic [AW-1:0]                 wr_addr,
	input  wire logic [enfp_pkg::SAMPLE_W-1:0] wr_data
);
	import enfp_pkg::*;

	logic [SAMPLE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]    valid_q;
	logic [SAMPLE_W-1:0] rd_q;
	logic                rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// An entry that was never written holds the preset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : SAMPLE_W'(PRESET);

endmodule

`default_nettype wire

>>> src/enfp_floor.sv
// Noise floor tracker: ring read, gated push, running sum and mean.
`default_nettype none

module enfp_floor #(
	parameter int CHANNELS     = enfp_pkg::CHANNELS_DEF,
	parameter int NOISE_DEPTH  = enfp_pkg::NOISE_DEPTH_DEF,
	parameter int NOISE_PRESET = enfp_pkg::NOISE_PRESET_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          ent_valid,
	input  wire logic                          ent_tick,
	input  wire logic                          ent_ch,
	input  wire logic [enfp_pkg::SAMPLE_W-1:0] ent_smp,
	input  wire logic [enfp_pkg::SAMPLE_W-1:0] thr3,
	output enfp_pkg::floor_res_t               res
);
	import enfp_pkg::*;

	localparam int SW   = $clog2(NOISE_DEPTH * 1023 + 1);
	localparam int SLW  = $clog2(NOISE_DEPTH);
	localparam int AW   = $clog2(CHANNELS * NOISE_DEPTH);
	localparam int LW   = $clog2(NOISE_DEPTH * 1024 + 1);
	localparam int KW   = SAMPLE_W + 2;
	localparam int DIVK = SW + SLW;
	localparam int MW   = SW + 1;
	localparam int PRW  = SW + MW;
	localparam longint RECIP_VAL =
		((longint'(1) << DIVK) + longint'(NOISE_DEPTH) - 1) / longint'(NOISE_DEPTH);
	localparam logic [MW-1:0]  RECIP     = MW'(RECIP_VAL);
	localparam logic [SW-1:0]  SUM_RESET = SW'(NOISE_DEPTH * NOISE_PRESET);
	localparam logic [SW-1:0]  SUM_MAX   = SW'(NOISE_DEPTH * 1023);
	localparam logic [SLW-1:0] SLOT_LAST = SLW'(NOISE_DEPTH - 1);
	localparam logic [LW-1:0]  DEPTH_L   = LW'(NOISE_DEPTH);

	logic [SW-1:0]  sum_q [CHANNELS];
	logic [SLW-1:0] slot_q [CHANNELS];

	logic                v_s1, tick_s1, ch_s1;
	logic [SAMPLE_W-1:0] smp_s1;
	logic [AW-1:0]       addr_s1;
	logic                v_s2, tick_s2, ch_s2;
	logic [SAMPLE_W-1:0] smp_s2;
	logic [SW-1:0]       sum_s2;
	logic                v_s3, tick_s3, ch_s3;
	logic [SAMPLE_W-1:0] smp_s3;
	logic [PRW-1:0]      prod_s3;

	logic [SAMPLE_W-1:0] rd_data;
	logic [SW-1:0]       sum_cur, new_sum;
	logic [SLW-1:0]      slot_cur, slot_nxt, ent_slot;
	logic [KW-1:0]       kx;
	logic [LW-1:0]       lim;
	logic                push, sample_go, do_push, rd_en;
	logic [AW-1:0]       ent_addr;

	// mean >= k is the same as sum >= depth * k, so the gate needs no mean.
	assign sum_cur   = sum_q[ch_s1];
	assign slot_cur  = slot_q[ch_s1];
	assign kx        = KW'(smp_s1) + KW'(1) - KW'(thr3);
	assign lim       = LW'(DEPTH_L * LW'(kx[SAMPLE_W:0]));
	assign push      = kx[KW-1] || (kx == '0) || (LW'(sum_cur) >= lim);
	assign sample_go = v_s1 && !tick_s1;
	assign do_push   = sample_go && push;
	assign new_sum   = sum_cur - SW'(rd_data) + SW'(smp_s1);
	assign slot_nxt  = (slot_cur == SLOT_LAST) ? '0 : slot_cur + 1'b1;

	// The slot of an entering item sees a push of the item just ahead.
	assign ent_slot = (do_push && (ch_s1 == ent_ch)) ? slot_nxt : slot_q[ent_ch];
	assign ent_addr = AW'(AW'(ent_ch) * AW'(NOISE_DEPTH)) + AW'(ent_slot);
	assign rd_en    = adv && ent_valid && !ent_tick;

	enfp_noise_ram #(
		.DEPTH  (CHANNELS * NOISE_DEPTH),
		.AW     (AW),
		.PRESET (NOISE_PRESET)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (ent_addr),
		.rd_data (rd_data),
		.wr_en   (adv && do_push),
		.wr_addr (addr_s1),
		.wr_data (smp_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				sum_q[c]  <= SUM_RESET;
				slot_q[c] <= '0;
			end
		end else if (adv) begin
			v_s1 <= ent_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (do_push) begin
				sum_q[ch_s1]  <= new_sum;
				slot_q[ch_s1] <= slot_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tick_s1 <= ent_tick;
			ch_s1   <= ent_ch;
			smp_s1  <= ent_smp;
			addr_s1 <= ent_addr;
			tick_s2 <= tick_s1;
			ch_s2   <= ch_s1;
			smp_s2  <= smp_s1;
			sum_s2  <= do_push ? new_sum : sum_cur;
			tick_s3 <= tick_s2;
			ch_s3   <= ch_s2;
			smp_s3  <= smp_s2;
			prod_s3 <= PRW'(sum_s2) * PRW'(RECIP);
		end
	end

	assign res.valid = v_s3;
	assign res.tick  = tick_s3;
	assign res.ch    = ch_s3;
	assign res.smp   = smp_s3;
	assign res.mean  = prod_s3[DIVK +: SAMPLE_W];

	a_no_ram_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && adv && do_push) |-> (ent_addr != addr_s1))
		else $error("noise store read and write hit the same entry");

	for (genvar c = 0; c < CHANNELS; c++) begin : g_chk
		a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
			slot_q[c] <= SLOT_LAST)
			else $error("write slot beyond ring depth");
		a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
			sum_q[c] <= SUM_MAX)
			else $error("noise sum beyond ring capacity");
	end

endmodule

`default_nettype wire

>>> src/enfp_peak.sv
// Peak and hold tracker: amplitude, threshold crossings and hold timers.
`default_nettype none

module enfp_peak #(
	parameter int CHANNELS = enfp_pkg::CHANNELS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire enfp_pkg::floor_res_t          item,
	input  wire logic [enfp_pkg::SAMPLE_W-1:0] thr,
	input  wire logic [enfp_pkg::TICKS_W-1:0]  hold_ticks,
	output enfp_pkg::result_t                  res,
	output logic                               res_valid
);
	import enfp_pkg::*;

	logic [SAMPLE_W-1:0] last_q [CHANNELS];
	logic                peak_q [CHANNELS];
	logic                hold_q [CHANNELS];
	logic                run_q  [CHANNELS];
	logic [TICKS_W-1:0]  cnt_q  [CHANNELS];

	logic [SAMPLE_W-1:0] amp, prev;
	logic                n_peak, n_hold, n_run;
	logic [TICKS_W-1:0]  n_cnt;

	always_comb begin
		amp    = (item.smp > item.mean) ? item.smp - item.mean : '0;
		prev   = last_q[item.ch];
		n_peak = peak_q[item.ch];
		n_hold = hold_q[item.ch];
		n_run  = run_q[item.ch];
		n_cnt  = cnt_q[item.ch];
		if (amp == '0) begin
			n_peak = 1'b0;
			n_hold = 1'b0;
			n_run  = 1'b0;
		end else begin
			if (n_run && (n_cnt >= hold_ticks) && !n_hold) begin
				n_hold = 1'b1;
				n_run  = 1'b0;
			end
			if ((prev < thr) && (amp >= thr)) begin
				n_run = 1'b1;
				n_cnt = '0;
				if (CHANNELS > 1) begin
					n_peak = 1'b1;
				end
			end else if ((prev >= thr) && (amp < thr)) begin
				n_run = 1'b0;
				// A one-channel build marks the peak at its falling edge.
				if (CHANNELS == 1) begin
					if (!n_hold) begin
						n_peak = 1'b1;
					end
				end else begin
					n_peak = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				last_q[c] <= '0;
				peak_q[c] <= 1'b0;
				hold_q[c] <= 1'b0;
				run_q[c]  <= 1'b0;
				cnt_q[c]  <= '0;
			end
		end else if (adv && item.valid) begin
			if (item.tick) begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (run_q[c] && (cnt_q[c] != TICK_MAX)) begin
						cnt_q[c] <= cnt_q[c] + 1'b1;
					end
				end
			end else begin
				last_q[item.ch] <= amp;
				peak_q[item.ch] <= n_peak;
				hold_q[item.ch] <= n_hold;
				run_q[item.ch]  <= n_run;
				cnt_q[item.ch]  <= n_cnt;
			end
		end
	end

	assign res_valid  = item.valid && !item.tick;
	assign res.ch     = item.ch;
	assign res.amp    = amp;
	assign res.active = (amp != '0);
	assign res.peak   = n_peak;
	assign res.hold   = n_hold;
	assign res.mean   = item.mean;

	a_idle_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.active) |-> (!res.peak && !res.hold))
		else $error("inactive sample left peak or hold set");

	a_hold_needs_time: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !hold_q[item.ch] && n_hold) |->
		(run_q[item.ch] && (cnt_q[item.ch] >= hold_ticks)))
		else $error("hold set before the timer reached hold time");

	a_timer_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item.valid && item.tick && (cnt_q[0] == TICK_MAX)) |=>
		(cnt_q[0] == TICK_MAX))
		else $error("hold timer wrapped");

endmodule

`default_nettype wire
